@@ sv/sbrp_pkg.sv @@
// Shared constants, codes and inter-module structs for the STUN binding response parser.
package sbrp_pkg;

  localparam int CNT_W    = 17;
  localparam int LEN_W    = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W    = 64;

  localparam logic [CNT_W-1:0] COUNT_MAX    = 17'h1FFFF;
  localparam logic [CNT_W-1:0] HEADER_BYTES = 17'd20;
  localparam logic [CNT_W-1:0] TXID_FIRST   = 17'd8;

  localparam logic [15:0] TYPE_BINDING_SUCCESS = 16'h0101;
  localparam logic [15:0] TYPE_XOR_MAPPED      = 16'h0020;
  localparam logic [7:0]  FAMILY_IPV4          = 8'h01;
  localparam logic [31:0] MAGIC_COOKIE         = 32'h2112A442;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TXID_HIGH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TXID_LOW  = 1'b1;

  // Result status codes
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_SHORT        = 3'd1;
  localparam logic [2:0] ST_WRONG_TYPE   = 3'd2;
  localparam logic [2:0] ST_TXID_BAD     = 3'd3;
  localparam logic [2:0] ST_LEN_OVERRUN  = 3'd4;
  localparam logic [2:0] ST_ATTR_OVERRUN = 3'd5;
  localparam logic [2:0] ST_NOT_FOUND    = 3'd6;

  // Attribute walk outcome codes
  localparam logic [1:0] OC_PENDING = 2'd0;
  localparam logic [1:0] OC_FOUND   = 2'd1;
  localparam logic [1:0] OC_OVERRUN = 2'd2;

  typedef struct packed {
    logic [CNT_W-1:0] pos;         // byte position of the word being processed
    logic [CNT_W-1:0] end_pos;     // first byte past the attribute region
    logic             walk_en;     // word lies inside the attribute region
    logic [CNT_W-1:0] size;        // byte count including this word
    logic             type_ok;
    logic             txid_bad;
    logic             len_overrun;
  } hdr_info_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [31:0] addr;
    logic [15:0] port;
  } walk_res_t;

endpackage

@@ sv/sbrp_in_if.sv @@
// Byte input channel: one message byte and a last-byte flag per word.
interface sbrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

@@ sv/sbrp_out_if.sv @@
// Result channel: parse status with decoded IPv4 address and port.
interface sbrp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] mapped_addr;
  logic [15:0] mapped_port;

  modport source (output valid, output status, output mapped_addr, output mapped_port,
                  input ready);
  modport sink   (input valid, input status, input mapped_addr, input mapped_port,
                  output ready);
endinterface

@@ sv/sbrp_hdr.sv @@
// Header tracker: byte counter, type, length, transaction ID compare and config registers.
module sbrp_hdr (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [sbrp_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [sbrp_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              step,
  input  logic                              clear,
  input  logic [7:0]                        data_byte,
  output sbrp_pkg::hdr_info_t               info
);
  import sbrp_pkg::*;

  logic [31:0]      txid_high_r, txid_high_nxt;
  logic [63:0]      txid_low_r, txid_low_nxt;
  logic [CNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [15:0]      msg_type_r, msg_type_nxt;
  logic [LEN_W-1:0] attr_len_r, attr_len_nxt;
  logic             txid_diff_r, txid_diff_nxt;

  logic [95:0]      txid_all;
  logic [7:0]       txid_bytes [12];
  logic [3:0]       txid_i;
  logic [7:0]       want;
  logic             live;
  logic             in_txid;
  logic [CNT_W-1:0] count_upd;
  logic [15:0]      msg_type_upd;
  logic [LEN_W-1:0] attr_len_upd;
  logic             txid_upd;

  assign txid_all = {txid_high_r, txid_low_r};

  always_comb begin
    for (int k = 0; k < 12; k++) begin
      txid_bytes[k] = txid_all[95 - 8*k -: 8];
    end
  end

  assign live    = (byte_count_r != COUNT_MAX);
  assign in_txid = (byte_count_r >= TXID_FIRST) && (byte_count_r < HEADER_BYTES);
  assign txid_i  = byte_count_r[3:0] - 4'd8;
  assign want    = (txid_i < 4'd12) ? txid_bytes[txid_i] : 8'h00;

  always_comb begin
    msg_type_upd = msg_type_r;
    attr_len_upd = attr_len_r;
    txid_upd     = txid_diff_r;
    count_upd    = byte_count_r;
    if (live) begin
      count_upd = byte_count_r + 17'd1;
      if (byte_count_r == 17'd0) begin
        msg_type_upd = {data_byte, 8'h00};
      end else if (byte_count_r == 17'd1) begin
        msg_type_upd = {msg_type_r[15:8], data_byte};
      end else if (byte_count_r == 17'd2) begin
        attr_len_upd = {data_byte, 8'h00};
      end else if (byte_count_r == 17'd3) begin
        attr_len_upd = {attr_len_r[15:8], data_byte};
      end else if (in_txid && (want != data_byte)) begin
        txid_upd = 1'b1;
      end
    end
  end

  always_comb begin
    info.pos         = byte_count_r;
    info.end_pos     = HEADER_BYTES + {1'b0, attr_len_r};
    info.walk_en     = live && (byte_count_r >= HEADER_BYTES) && (byte_count_r < info.end_pos);
    info.size        = count_upd;
    info.type_ok     = (msg_type_upd == TYPE_BINDING_SUCCESS);
    info.txid_bad    = txid_upd;
    info.len_overrun = ((HEADER_BYTES + {1'b0, attr_len_upd}) > count_upd);
  end

  always_comb begin
    txid_high_nxt = txid_high_r;
    txid_low_nxt  = txid_low_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_TXID_HIGH: txid_high_nxt = cfg_data[31:0];
        CFG_TXID_LOW:  txid_low_nxt  = cfg_data;
        default:       txid_high_nxt = txid_high_r;
      endcase
    end
    byte_count_nxt = byte_count_r;
    msg_type_nxt   = msg_type_r;
    attr_len_nxt   = attr_len_r;
    txid_diff_nxt  = txid_diff_r;
    if (step) begin
      if (clear) begin
        byte_count_nxt = '0;
        msg_type_nxt   = '0;
        attr_len_nxt   = '0;
        txid_diff_nxt  = 1'b0;
      end else begin
        byte_count_nxt = count_upd;
        msg_type_nxt   = msg_type_upd;
        attr_len_nxt   = attr_len_upd;
        txid_diff_nxt  = txid_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      txid_high_r  <= '0;
      txid_low_r   <= '0;
      byte_count_r <= '0;
      msg_type_r   <= '0;
      attr_len_r   <= '0;
      txid_diff_r  <= 1'b0;
    end else begin
      txid_high_r  <= txid_high_nxt;
      txid_low_r   <= txid_low_nxt;
      byte_count_r <= byte_count_nxt;
      msg_type_r   <= msg_type_nxt;
      attr_len_r   <= attr_len_nxt;
      txid_diff_r  <= txid_diff_nxt;
    end
  end

endmodule

@@ sv/sbrp_walk.sv @@
// Attribute walker: steps through padded TLVs and captures the first IPv4 XOR-MAPPED-ADDRESS.
module sbrp_walk (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic                  clear,
  input  logic [7:0]            data_byte,
  input  sbrp_pkg::hdr_info_t   info,
  output sbrp_pkg::walk_res_t   res
);
  import sbrp_pkg::*;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_CAND   = 2'd1;
  localparam logic [1:0] PH_SKIP   = 2'd2;

  function automatic logic [CNT_W-1:0] padded_len(input logic [LEN_W-1:0] len);
    logic [1:0] pad;
    pad = 2'd0 - len[1:0];
    return {1'b0, len} + {15'd0, pad};
  endfunction

  logic [1:0]       phase_r, phase_nxt, phase_upd;
  logic [31:0]      hdr_r, hdr_nxt, hdr_upd;
  logic [CNT_W-1:0] left_r, left_nxt, left_upd;
  logic [1:0]       outcome_r, outcome_nxt, outcome_upd;
  logic [31:0]      addr_r, addr_nxt, addr_upd;
  logic [15:0]      port_r, port_nxt, port_upd;

  logic             active;
  logic [LEN_W-1:0] new_len;
  logic [15:0]      new_type;
  logic [CNT_W:0]   reach;
  logic [CNT_W-1:0] new_total;
  logic [CNT_W-1:0] cur_total;
  logic [CNT_W-1:0] off;
  logic [CNT_W-1:0] left_dec;

  assign active    = info.walk_en && (outcome_r == OC_PENDING);
  assign new_len   = {hdr_r[7:0], data_byte};
  assign new_type  = hdr_r[23:8];
  assign reach     = {1'b0, info.pos} + 18'd1 + {2'b00, new_len};
  assign new_total = padded_len(new_len);
  assign cur_total = padded_len(hdr_r[15:0]);
  assign off       = cur_total - left_r;
  assign left_dec  = left_r - 17'd1;

  always_comb begin
    phase_upd   = phase_r;
    hdr_upd     = hdr_r;
    left_upd    = left_r;
    outcome_upd = outcome_r;
    addr_upd    = addr_r;
    port_upd    = port_r;
    if (phase_r == PH_HEADER) begin
      hdr_upd  = {hdr_r[23:0], data_byte};
      left_upd = left_r + 17'd1;
      if (left_r[1:0] == 2'd3) begin
        // Full type and length collected: check the value fits the region
        if (reach > {1'b0, info.end_pos}) begin
          outcome_upd = OC_OVERRUN;
        end else if (new_len == '0) begin
          hdr_upd  = '0;
          left_upd = '0;
        end else begin
          phase_upd = ((new_type == TYPE_XOR_MAPPED) && (new_len >= 16'd8)) ? PH_CAND : PH_SKIP;
          left_upd  = new_total;
        end
      end
    end else begin
      if (phase_r == PH_CAND) begin
        if ((off == 17'd1) && (data_byte != FAMILY_IPV4)) begin
          phase_upd = PH_SKIP;
        end else if ((off == 17'd2) || (off == 17'd3)) begin
          port_upd = {port_r[7:0], data_byte};
        end else if ((off >= 17'd4) && (off <= 17'd7)) begin
          addr_upd = {addr_r[23:0], data_byte};
        end
      end
      if ((phase_r == PH_CAND) && (off == 17'd7)) begin
        outcome_upd = OC_FOUND;
      end else begin
        left_upd = left_dec;
        if (left_dec == '0) begin
          phase_upd = PH_HEADER;
          hdr_upd   = '0;
        end
      end
    end
  end

  always_comb begin
    res.outcome = active ? outcome_upd : outcome_r;
    res.addr    = active ? addr_upd    : addr_r;
    res.port    = active ? port_upd    : port_r;
  end

  always_comb begin
    phase_nxt   = phase_r;
    hdr_nxt     = hdr_r;
    left_nxt    = left_r;
    outcome_nxt = outcome_r;
    addr_nxt    = addr_r;
    port_nxt    = port_r;
    if (step) begin
      if (clear) begin
        phase_nxt   = PH_HEADER;
        hdr_nxt     = '0;
        left_nxt    = '0;
        outcome_nxt = OC_PENDING;
        addr_nxt    = '0;
        port_nxt    = '0;
      end else if (active) begin
        phase_nxt   = phase_upd;
        hdr_nxt     = hdr_upd;
        left_nxt    = left_upd;
        outcome_nxt = outcome_upd;
        addr_nxt    = addr_upd;
        port_nxt    = port_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      hdr_r     <= '0;
      left_r    <= '0;
      outcome_r <= OC_PENDING;
      addr_r    <= '0;
      port_r    <= '0;
    end else begin
      phase_r   <= phase_nxt;
      hdr_r     <= hdr_nxt;
      left_r    <= left_nxt;
      outcome_r <= outcome_nxt;
      addr_r    <= addr_nxt;
      port_r    <= port_nxt;
    end
  end

endmodule

@@ sv/stun_binding_response_parser.sv @@
// Top level of the STUN binding response parser: input stage, header/walk units, result register.
//
//   channel | dir | handshake        | payload
//   in_ch   | in  | valid / ready    | data_byte[7:0], final_byte
//   out_ch  | out | valid / ready    | status[2:0], mapped_addr[31:0], mapped_port[15:0]
//   cfg_*   | in  | cfg_we (no wait) | cfg_idx[0], cfg_data[63:0]
//
// Flow: one byte word per clock, but for a last-byte word held by a stall (below); a word
// sits in the input register while the header and walk state update from it. A last-byte
// word moves from the input register into the result register once that register is free.
// Reset: rst_n synchronous, active low; clears hdr/walk state, valid bits, both config registers.
// Stalls: out_ch.ready low holds a last-byte word in the input register once a result is
// waiting; other words keep flowing.
module stun_binding_response_parser (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [sbrp_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [sbrp_pkg::CFG_W-1:0]     cfg_data,
  sbrp_in_if.sink                        in_ch,
  sbrp_out_if.source                     out_ch
);
  import sbrp_pkg::*;

  // Input register
  logic        s1_v_r, s1_v_nxt;
  logic [7:0]  s1_byte_r, s1_byte_nxt;
  logic        s1_fin_r, s1_fin_nxt;

  // Result register
  logic        out_v_r, out_v_nxt;
  logic [2:0]  out_status_r, out_status_nxt;
  logic [31:0] out_addr_r, out_addr_nxt;
  logic [15:0] out_port_r, out_port_nxt;

  logic        out_free;
  logic        s1_go;
  logic        step;
  logic        accept;
  logic        finish;
  logic [2:0]  status;
  logic [31:0] addr;
  logic [15:0] port;

  hdr_info_t   hdr_info;
  walk_res_t   walk_res;

  // A last-byte word may only advance when the result register can take it
  assign out_free = !out_v_r || out_ch.ready;
  assign s1_go    = !s1_fin_r || out_free;
  assign step     = s1_v_r && s1_go;
  assign finish   = step && s1_fin_r;

  assign in_ch.ready = !s1_v_r || s1_go;
  assign accept      = in_ch.valid && in_ch.ready;

  sbrp_hdr u_hdr (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .step      (step),
    .clear     (s1_fin_r),
    .data_byte (s1_byte_r),
    .info      (hdr_info)
  );

  sbrp_walk u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .clear     (s1_fin_r),
    .data_byte (s1_byte_r),
    .info      (hdr_info),
    .res       (walk_res)
  );

  // Report the first failing check in order; address and port only on success
  always_comb begin
    addr = '0;
    port = '0;
    priority if (hdr_info.size < HEADER_BYTES) begin
      status = ST_SHORT;
    end else if (!hdr_info.type_ok) begin
      status = ST_WRONG_TYPE;
    end else if (hdr_info.txid_bad) begin
      status = ST_TXID_BAD;
    end else if (hdr_info.len_overrun) begin
      status = ST_LEN_OVERRUN;
    end else if (walk_res.outcome == OC_OVERRUN) begin
      status = ST_ATTR_OVERRUN;
    end else if (walk_res.outcome == OC_FOUND) begin
      status = ST_OK;
      addr   = walk_res.addr ^ MAGIC_COOKIE;
      port   = walk_res.port ^ MAGIC_COOKIE[31:16];
    end else begin
      status = ST_NOT_FOUND;
    end
  end

  always_comb begin
    s1_v_nxt    = s1_v_r;
    s1_byte_nxt = s1_byte_r;
    s1_fin_nxt  = s1_fin_r;
    if (accept) begin
      s1_v_nxt    = 1'b1;
      s1_byte_nxt = in_ch.data_byte;
      s1_fin_nxt  = in_ch.final_byte;
    end else if (step) begin
      s1_v_nxt = 1'b0;
    end

    out_v_nxt      = out_v_r;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    out_port_nxt   = out_port_r;
    if (finish) begin
      out_v_nxt      = 1'b1;
      out_status_nxt = status;
      out_addr_nxt   = addr;
      out_port_nxt   = port;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Payload: no reset needed
  always_ff @(posedge clk) begin
    s1_byte_r    <= s1_byte_nxt;
    s1_fin_r     <= s1_fin_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_port_r   <= out_port_nxt;
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.mapped_addr = out_addr_r;
  assign out_ch.mapped_port = out_port_r;

`ifndef ASSERT_OFF
  a_clear_after_final: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> (hdr_info.pos == '0))
    else $error("byte count not cleared after last byte");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> out_v_r)
    else $error("last byte advanced without a result");

  a_fail_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (out_status_r != ST_OK)) |-> ((out_addr_r == '0) && (out_port_r == '0)))
    else $error("failed result carries address or port");

  a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_v_r |-> in_ch.ready)
    else $error("empty input stage refuses a word");
`endif

endmodule

@@ tb/sv/tb_stun_binding_response_parser.sv @@
// Self-checking testbench for the STUN binding response parser: directed table plus random messages.
`timescale 1ns / 1ps

module tb_stun_binding_response_parser;
  import sbrp_pkg::*;

  localparam int SETTLE_CYCLES = 10;   // margin after the last result
  localparam int PHASE_WORDS   = 250;
  localparam int PHASE_MSGS    = 8;

  // Walk phase of the attribute scanner in the predictor
  typedef enum logic [1:0] {WALK_HDR, WALK_CAND, WALK_SKIP} walk_phase_e;

  // Shapes of generated messages
  typedef enum int {
    MSG_GOOD, MSG_SHORT, MSG_BAD_TYPE, MSG_BAD_TXID,
    MSG_LEN_OVER, MSG_ATTR_OVER, MSG_CUT_REGION, MSG_NOISE
  } msg_kind_e;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] addr;
    logic [15:0] port;
  } parse_result_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        typed;    // 1: result below is the expectation, 0: predictor decides
    logic [2:0]  status;
    logic [31:0] addr;
    logic [15:0] port;
  } dir_row_t;

  // Directed words: a one-byte message, a bare 20-byte header matching the reset
  // transaction ID, then a three-byte message left to the predictor.
  localparam dir_row_t DIR_TABLE [24] = '{
    '{8'hFF, 1'b1, 1'b1, ST_SHORT,     32'h0, 16'h0},
    '{8'h01, 1'b0, 1'b0, ST_OK,        32'h0, 16'h0},
    '{8'h01, 1'b0, 1'b0, ST_OK,        32'h0, 16'h0},
    '{8'h00, 1'b0, 1'b0, ST_OK,        32'h0, 16'h0},
    '{8'h00, 1'b0, 1'b0, ST_OK,        32'h0, 16'h0},
    '{8'h21, 1'b0, 1'b0, ST_OK,        32'h0, 16'h0},
    '{8'h12, 1'b0, 1'b0, ST_OK,        32'h0, 16'h0},
    '{8'hA4, 1'b0, 1'b0, ST_OK,        32'h0, 16'h0},
    '{8'h42, 1'b0, 1'b0, ST_OK,        32'h0, 16'h0},
    '{8'h00, 1'b0, 1'b0, ST_OK,        32'h0, 16'h0},
    '{8'h00, 1'b0, 1'b0, ST_OK,        32'h0, 16'h0},
    '{8'h00, 1'b0, 1'b0, ST_OK,        32'h0, 16'h0},
    '{8'h00, 1'b0, 1'b0, ST_OK,        32'h0, 16'h0},
    '{8'h00, 1'b0, 1'b0, ST_OK,        32'h0, 16'h0},
    '{8'h00, 1'b0, 1'b0, ST_OK,        32'h0, 16'h0},
    '{8'h00, 1'b0, 1'b0, ST_OK,        32'h0, 16'h0},
    '{8'h00, 1'b0, 1'b0, ST_OK,        32'h0, 16'h0},
    '{8'h00, 1'b0, 1'b0, ST_OK,        32'h0, 16'h0},
    '{8'h00, 1'b0, 1'b0, ST_OK,        32'h0, 16'h0},
    '{8'h00, 1'b0, 1'b0, ST_OK,        32'h0, 16'h0},
    '{8'h00, 1'b1, 1'b1, ST_NOT_FOUND, 32'h0, 16'h0},
    '{8'h00, 1'b0, 1'b0, ST_OK,        32'h0, 16'h0},
    '{8'h80, 1'b0, 1'b0, ST_OK,        32'h0, 16'h0},
    '{8'hFF, 1'b1, 1'b0, ST_OK,        32'h0, 16'h0}
  };

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  sbrp_in_if  in_ch ();
  sbrp_out_if out_ch ();

  stun_binding_response_parser u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor copy of the configuration and per-message parse state
  logic [31:0]  want_hi;
  logic [63:0]  want_lo;
  logic [16:0]  seen_cnt;
  logic [15:0]  msg_type;
  logic [15:0]  region_len;
  logic         txid_bad;
  walk_phase_e  phase;
  logic [31:0]  tlv_hdr;
  logic [16:0]  tlv_left;
  logic [1:0]   outcome;
  logic [31:0]  addr_acc;
  logic [15:0]  port_acc;

  parse_result_t expected_results [$];
  dir_row_t      typed_rows [$];
  logic [7:0]    msg [$];
  logic [7:0]    body [$];

  int  mismatch_cnt;
  int  results_checked;
  int  words_sent;
  int  msgs_sent;
  int  settings_cnt;
  bit  in_calm;
  bit  out_calm;
  int  ready_hold;

  function automatic int pad4(input int len);
    return len + ((4 - (len & 3)) & 3);
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 99) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Bias toward zero, all ones and the cookie itself so decoded fields hit their extremes
  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 32'h0;
    if (r < 20) return '1;
    if (r < 30) return MAGIC_COOKIE;
    if (r < 40) return ~MAGIC_COOKIE;
    return $urandom;
  endfunction

  function automatic void clear_parse_state();
    seen_cnt   = '0;
    msg_type   = '0;
    region_len = '0;
    txid_bad   = 1'b0;
    phase      = WALK_HDR;
    tlv_hdr    = '0;
    tlv_left   = '0;
    outcome    = OC_PENDING;
    addr_acc   = '0;
    port_acc   = '0;
  endfunction

  // Advance the attribute walk by one word inside the attribute region
  function automatic void walk_attr_byte(input int pos, input logic [7:0] b, input int stop);
    int total;
    int off;
    if (phase == WALK_HDR) begin
      tlv_hdr  = {tlv_hdr[23:0], b};
      tlv_left = tlv_left + 17'd1;
      if (tlv_left < 4) return;
      if (pos + 1 + int'(tlv_hdr[15:0]) > stop) begin
        outcome = OC_OVERRUN;
        return;
      end
      total = pad4(int'(tlv_hdr[15:0]));
      if (total == 0) begin
        tlv_hdr  = '0;
        tlv_left = '0;
      end else begin
        phase = (tlv_hdr[31:16] == TYPE_XOR_MAPPED && tlv_hdr[15:0] >= 16'd8) ?
                WALK_CAND : WALK_SKIP;
        tlv_left = 17'(total);
      end
      return;
    end
    total = pad4(int'(tlv_hdr[15:0]));
    off   = total - int'(tlv_left);
    if (phase == WALK_CAND) begin
      if (off == 1 && b != FAMILY_IPV4)
        phase = WALK_SKIP;
      else if (off == 2 || off == 3)
        port_acc = {port_acc[7:0], b};
      else if (off >= 4 && off <= 7)
        addr_acc = {addr_acc[23:0], b};
      if (off == 7 && phase == WALK_CAND) begin
        outcome = OC_FOUND;
        return;
      end
    end
    tlv_left = tlv_left - 17'd1;
    if (tlv_left == 0) begin
      phase   = WALK_HDR;
      tlv_hdr = '0;
    end
  endfunction

  // Fold one accepted word into the parse state; return 1 with the result on a last word
  function automatic logic parse_byte(input logic [7:0] b, input logic fin,
                                      output parse_result_t res);
    int pos;
    int stop;
    int i;
    logic [7:0] want;
    pos  = int'(seen_cnt);
    stop = int'(HEADER_BYTES) + int'(region_len);
    res  = '0;
    if (pos < int'(COUNT_MAX)) begin
      if (pos == 0)
        msg_type = {b, 8'h00};
      else if (pos == 1)
        msg_type = msg_type | {8'h00, b};
      else if (pos == 2)
        region_len = {b, 8'h00};
      else if (pos == 3)
        region_len = region_len | {8'h00, b};
      else if (pos >= int'(TXID_FIRST) && pos < int'(HEADER_BYTES)) begin
        i = pos - int'(TXID_FIRST);
        want = (i < 4) ? want_hi[8*(3-i) +: 8] : want_lo[8*(11-i) +: 8];
        if (want != b) txid_bad = 1'b1;
      end else if (pos >= int'(HEADER_BYTES) && pos < stop && outcome == OC_PENDING)
        walk_attr_byte(pos, b, stop);
      seen_cnt = 17'(pos + 1);
    end
    if (!fin) return 1'b0;
    // Error precedence follows the order of the checks
    if (seen_cnt < HEADER_BYTES)
      res.status = ST_SHORT;
    else if (msg_type != TYPE_BINDING_SUCCESS)
      res.status = ST_WRONG_TYPE;
    else if (txid_bad)
      res.status = ST_TXID_BAD;
    else if (int'(HEADER_BYTES) + int'(region_len) > int'(seen_cnt))
      res.status = ST_LEN_OVERRUN;
    else if (outcome == OC_OVERRUN)
      res.status = ST_ATTR_OVERRUN;
    else if (outcome == OC_FOUND) begin
      res.status = ST_OK;
      res.addr   = addr_acc ^ MAGIC_COOKIE;
      res.port   = port_acc ^ MAGIC_COOKIE[31:16];
    end else
      res.status = ST_NOT_FOUND;
    clear_parse_state();
    return 1'b1;
  endfunction

  task automatic note_failure(input string what, input logic [63:0] want,
                              input logic [63:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
  endtask

  // Predict on every accepted word; directed rows with a typed result override the predictor
  always @(posedge clk) begin : watch_words
    parse_result_t res;
    dir_row_t      row;
    logic          done;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      done = parse_byte(in_ch.data_byte, in_ch.final_byte, res);
      if (done) begin
        if (typed_rows.size() != 0) begin
          row = typed_rows.pop_front();
          if (row.typed) res = '{row.status, row.addr, row.port};
        end
        expected_results = {expected_results, res};
      end
    end
  end

  // Check every accepted result against the oldest expectation
  always @(posedge clk) begin : watch_results
    parse_result_t want_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_checked++;
      if (expected_results.size() == 0)
        note_failure("unexpected result status", 64'h0, 64'(out_ch.status));
      else begin
        want_r = expected_results.pop_front();
        if (out_ch.status !== want_r.status)
          note_failure("status", 64'(want_r.status), 64'(out_ch.status));
        if (out_ch.mapped_addr !== want_r.addr)
          note_failure("mapped_addr", 64'(want_r.addr), 64'(out_ch.mapped_addr));
        if (out_ch.mapped_port !== want_r.port)
          note_failure("mapped_port", 64'(want_r.port), 64'(out_ch.mapped_port));
      end
    end
  end

  // Result side back-pressure: random low stretches, or hold ready high in calm phases
  always @(posedge clk) begin
    if (out_calm) begin
      out_ch.ready <= 1'b1;
      ready_hold = 0;
    end else if (ready_hold > 0)
      ready_hold--;
    else if (out_ch.ready) begin
      out_ch.ready <= 1'b0;
      ready_hold = gap_len();
    end else begin
      out_ch.ready <= 1'b1;
      ready_hold = $urandom_range(0, 10);
    end
  end

  // Drive one word and hold it until the parser takes it, then maybe idle
  task automatic send_word(input logic [7:0] b, input logic fin);
    int gap;
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.final_byte <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
    gap = in_calm ? 0 : gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_message();
    for (int k = 0; k < msg.size(); k++)
      send_word(msg[k], k == msg.size() - 1);
    msgs_sent++;
  endtask

  // Stop sending and hold until every expected result has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_txid(input logic [31:0] hi, input logic [63:0] lo);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_TXID_HIGH;
    cfg_data <= {32'h0, hi};
    @(posedge clk);
    cfg_idx  <= CFG_TXID_LOW;
    cfg_data <= lo;
    @(posedge clk);
    cfg_we   <= 1'b0;
    want_hi = hi;
    want_lo = lo;
    settings_cnt++;
  endtask

  task automatic push_header(input logic [15:0] mtype, input logic [15:0] len);
    logic [31:0] cookie;
    cookie = ($urandom_range(0, 3) == 0) ? $urandom : MAGIC_COOKIE;  // cookie is not checked
    msg = {msg, mtype[15:8]};
    msg = {msg, mtype[7:0]};
    msg = {msg, len[15:8]};
    msg = {msg, len[7:0]};
    for (int k = 0; k < 4; k++) msg = {msg, cookie[8*(3-k) +: 8]};
    for (int k = 0; k < 4; k++) msg = {msg, want_hi[8*(3-k) +: 8]};
    for (int k = 0; k < 8; k++) msg = {msg, want_lo[8*(7-k) +: 8]};
  endtask

  // Append one TLV with random padding; shaped ones carry family, port and address
  task automatic push_attr(input logic [15:0] typ, input int len, input bit shaped,
                           input logic [7:0] fam);
    logic [31:0] addr;
    logic [15:0] port;
    logic [7:0]  b;
    addr = pick_word();
    port = 16'(pick_word() >> 16);
    body = {body, typ[15:8]};
    body = {body, typ[7:0]};
    body = {body, 8'(len >> 8)};
    body = {body, 8'(len)};
    for (int k = 0; k < pad4(len); k++) begin
      b = 8'($urandom);
      if (shaped) begin
        if (k == 1) b = fam;
        else if (k == 2) b = port[15:8];
        else if (k == 3) b = port[7:0];
        else if (k >= 4 && k <= 7) b = addr[8*(7-k) +: 8];
      end
      body = {body, b};
    end
  endtask

  task automatic push_filler();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60)
      push_attr(16'($urandom), $urandom_range(0, 8), 1'b0, 8'h00);
    else if (r < 80)  // right type, wrong family: skip it and walk on
      push_attr(TYPE_XOR_MAPPED, $urandom_range(8, 10), 1'b1,
                ($urandom_range(0, 1) != 0) ? 8'h00 : 8'($urandom_range(2, 255)));
    else              // right type but too short to hold an address
      push_attr(TYPE_XOR_MAPPED, $urandom_range(0, 7), 1'b1, FAMILY_IPV4);
  endtask

  // Mostly well-formed responses with random attributes; the rest broken in one way each
  task automatic build_message();
    msg_kind_e   kind;
    int          r;
    int          n;
    int          good_slot;
    int          region;
    int          k;
    logic [15:0] mtype;
    msg.delete();
    body.delete();
    r = $urandom_range(0, 99);
    if (r < 55)      kind = MSG_GOOD;
    else if (r < 61) kind = MSG_SHORT;
    else if (r < 67) kind = MSG_BAD_TYPE;
    else if (r < 73) kind = MSG_BAD_TXID;
    else if (r < 80) kind = MSG_LEN_OVER;
    else if (r < 87) kind = MSG_ATTR_OVER;
    else if (r < 94) kind = MSG_CUT_REGION;
    else             kind = MSG_NOISE;

    if (kind == MSG_SHORT || kind == MSG_NOISE) begin
      n = (kind == MSG_SHORT) ? $urandom_range(1, 19) : $urandom_range(1, 48);
      for (k = 0; k < n; k++) msg = {msg, 8'($urandom)};
      if ($urandom_range(0, 1) != 0) begin
        msg[0] = 8'h01;
        if (n > 1) msg[1] = 8'h01;
      end
      return;
    end

    n = $urandom_range(0, 3);
    good_slot = $urandom_range(0, n + 1);
    for (k = 0; k <= n; k++) begin
      if (k == good_slot)
        push_attr(TYPE_XOR_MAPPED, $urandom_range(8, 12), 1'b1,
                  ($urandom_range(0, 9) != 0) ? FAMILY_IPV4 : 8'($urandom));
      else
        push_filler();
    end
    region = body.size();
    mtype  = TYPE_BINDING_SUCCESS;
    case (kind)
      MSG_BAD_TYPE: mtype = mtype ^ (16'h1 << $urandom_range(0, 15));
      MSG_LEN_OVER: region = region + $urandom_range(1, 12);
      MSG_ATTR_OVER: begin
        // trailing header whose length runs past the region end
        r = $urandom_range(1, 300);
        body = {body, 8'($urandom)};
        body = {body, 8'($urandom)};
        body = {body, 8'(r >> 8)};
        body = {body, 8'(r)};
        region = body.size();
      end
      MSG_CUT_REGION: if (region > 0) region = region - $urandom_range(1, (region < 3) ? region : 3);
      default: ;
    endcase
    push_header(mtype, 16'(region));
    foreach (body[j]) msg = {msg, body[j]};
    if (kind == MSG_BAD_TXID) begin
      k = $urandom_range(int'(TXID_FIRST), int'(HEADER_BYTES) - 1);
      msg[k] = msg[k] ^ (8'h1 << $urandom_range(0, 7));
    end
    // bytes past the attribute region take no part in the walk
    if (kind == MSG_GOOD && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 6)) msg = {msg, 8'($urandom)};
  endtask

  initial begin
    int phase_words;
    int phase_msgs;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_idx          <= CFG_TXID_HIGH;
    cfg_data         <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.data_byte  <= 8'h00;
    in_ch.final_byte <= 1'b0;
    want_hi = '0;
    want_lo = '0;
    clear_parse_state();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table against the reset configuration
    for (int i = 0; i < $size(DIR_TABLE); i++) begin
      if (DIR_TABLE[i].last) typed_rows = {typed_rows, DIR_TABLE[i]};
      send_word(DIR_TABLE[i].data, DIR_TABLE[i].last);
    end
    drain_results();

    // Random phases, each under its own transaction ID
    for (int ph = 1; ph <= 6; ph++) begin
      case (ph)
        1:       load_txid('1, '1);
        2:       load_txid('0, '0);
        5:       load_txid(32'hA5A5A5A5, 64'h5A5A5A5A5A5A5A5A);
        default: load_txid($urandom, {$urandom, $urandom});
      endcase
      in_calm  = (ph == 2);
      out_calm = (ph == 2);
      phase_words = 0;
      phase_msgs  = 0;
      while (phase_words < PHASE_WORDS || phase_msgs < PHASE_MSGS) begin
        build_message();
        send_message();
        phase_words += msg.size();
        phase_msgs++;
        if ($urandom_range(0, 7) == 0) drain_results();
      end
      drain_results();
    end
    out_calm = 1'b1;

    $display("covered %0d messages in %0d words under %0d transaction ID settings,",
             msgs_sent, words_sent, settings_cnt);
    $display("with random stalls on both sides; %0d results checked, %0d mismatches",
             results_checked, mismatch_cnt);
    if (mismatch_cnt == 0 && expected_results.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
